/* design/assert_macros.svh */
// Assertion macros used by the checker file of the parent context tracker.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* design/pctx_pkg.sv */
// Package for the preorder parent context tracker: sizes, transaction types and the
// code part mask function. Used by every module of the block; no dependencies.
package pctx_pkg;

    localparam int STACK_DEPTH   = 1024;
    localparam int MAX_PARTS     = 8;
    localparam int CODE_ALPHABET = (1 << 8);

    localparam int ADDR_W  = $clog2(STACK_DEPTH);
    localparam int FILL_W  = $clog2(STACK_DEPTH + 1);
    localparam int PART_W  = $clog2(CODE_ALPHABET);
    localparam int ID_W    = 24;
    localparam int CNT_W   = 16;
    localparam int CODES_W = 64;
    localparam int PARTS_W = 4;
    localparam int NUM_SLOTS = CODES_W / PART_W;

    localparam logic [ID_W-1:0]    ROOT_MAX      = {ID_W{1'b1}};
    localparam logic [PARTS_W-1:0] PARTS_RESET   = PARTS_W'(MAX_PARTS);

    typedef struct packed {
        logic [ID_W-1:0]    vtx_id;
        logic [CNT_W-1:0]   child_count;
        logic [CODES_W-1:0] current_codes;
        logic               last_in_tree;
    } t_in_item;

    typedef struct packed {
        logic               has_parent;
        logic [ID_W-1:0]    parent_id;
        logic [CODES_W-1:0] parent_codes;
        logic [CODES_W-1:0] child_codes;
        logic [ID_W-1:0]    component_count;
        logic               stack_overflow;
    } t_out_item;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [CNT_W-1:0]   remaining;
        logic [CODES_W-1:0] codes;
    } t_entry;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        t_entry            wr_data;
        logic [ADDR_W-1:0] rd_addr;
    } t_ram_req;

    function automatic logic [CODES_W-1:0] part_mask(input logic [PARTS_W-1:0] parts);
        logic [PARTS_W-1:0] p;
        logic [CODES_W-1:0] m;
        p = (parts > PARTS_W'(MAX_PARTS)) ? PARTS_W'(MAX_PARTS) : parts;
        m = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            m[i*PART_W +: PART_W] = (PARTS_W'(i) < p) ? {PART_W{1'b1}} : {PART_W{1'b0}};
        end
        return m;
    endfunction

endpackage

/* design/preorder_parent_context_tracker.sv */
// Top level of the preorder parent context tracker: input register, stack control,
// stack storage and result register. Uses pctx_pkg, pctx_ctrl and pctx_stack_ram.
// Each accepted input transaction is held in the input register and its result in the result register.
// Throughput is one transaction per cycle, with the top entry cached in registers and the
// entry below it prefetched from the stack storage; an output stall holds both registers.
// Synchronous active-low reset empties the stack, clears the root count and sets parts to 8.
module preorder_parent_context_tracker
    import pctx_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [PARTS_W-1:0] i_cfg_wr_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_item          o_out_data
);

    logic               r_in_valid;
    t_in_item           r_in;
    logic               r_out_valid;
    t_out_item          r_out;
    logic [PARTS_W-1:0] r_parts;

    logic      fire;
    logic      in_accept;
    t_out_item result;
    t_ram_req  ram_req;
    t_entry    sec_entry;

    assign fire       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !fire;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_parts     <= PARTS_RESET;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                r_parts <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_data;
        end
        if (fire) begin
            r_out <= result;
        end
    end

    pctx_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_item    (r_in),
        .i_parts   (r_parts),
        .i_sec     (sec_entry),
        .o_ram_req (ram_req),
        .o_result  (result)
    );

    pctx_stack_ram u_stack (
        .i_clk     (i_clk),
        .i_req     (ram_req),
        .o_rd_data (sec_entry)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* design/pctx_stack_ram.sv */
// Stack storage below the cached top entry: one write port and one registered read port.
// A read of the address written in the same cycle returns the new data. Uses pctx_pkg.
module pctx_stack_ram
    import pctx_pkg::*;
(
    input  logic     i_clk,
    input  t_ram_req i_req,
    output t_entry   o_rd_data
);

    t_entry r_mem [STACK_DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en && (i_req.wr_addr == i_req.rd_addr)) begin
            r_rd_data <= i_req.wr_data;
        end else begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/pctx_ctrl.sv */
// Stack control: cached top entry, fill count, root counter and result formation.
// Drives the stack storage request; uses pctx_pkg.
module pctx_ctrl
    import pctx_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  t_in_item           i_item,
    input  logic [PARTS_W-1:0] i_parts,
    input  t_entry             i_sec,
    output t_ram_req           o_ram_req,
    output t_out_item          o_result
);

    logic [FILL_W-1:0]  r_fill;
    logic [FILL_W-1:0]  n_fill;
    logic [ID_W-1:0]    r_roots;
    logic [ID_W-1:0]    n_roots;
    t_entry             r_top;
    t_entry             n_top;

    logic               has_parent;
    logic [CNT_W-1:0]   rem_dec;
    logic               pop;
    logic [FILL_W-1:0]  fill_a;
    logic               push_req;
    logic               push_ok;
    logic [ID_W-1:0]    roots_step;
    logic [CODES_W-1:0] mask;

    always_comb begin
        has_parent = (r_fill != '0);
        rem_dec    = (r_top.remaining != '0) ? (r_top.remaining - CNT_W'(1)) : '0;
        pop        = has_parent && (rem_dec == '0);
        fill_a     = r_fill - FILL_W'(pop);
        push_req   = (i_item.child_count != '0);
        push_ok    = push_req && (fill_a < FILL_W'(STACK_DEPTH));
        roots_step = (!has_parent && (r_roots != ROOT_MAX)) ? (r_roots + ID_W'(1)) : r_roots;
        mask       = part_mask(i_parts);
    end

    always_comb begin
        n_top = r_top;
        if (push_ok) begin
            n_top.id        = i_item.vtx_id;
            n_top.remaining = i_item.child_count;
            n_top.codes     = i_item.current_codes;
        end else if (pop) begin
            n_top = i_sec;
        end else if (has_parent) begin
            n_top.remaining = rem_dec;
        end
    end

    always_comb begin
        n_fill  = r_fill;
        n_roots = r_roots;
        if (i_fire) begin
            if (i_item.last_in_tree) begin
                n_fill  = '0;
                n_roots = '0;
            end else begin
                n_fill  = fill_a + FILL_W'(push_ok);
                n_roots = roots_step;
            end
        end
    end

    always_comb begin
        o_ram_req.wr_en             = i_fire && push_ok && has_parent && !pop;
        o_ram_req.wr_addr           = ADDR_W'(r_fill - FILL_W'(1));
        o_ram_req.wr_data.id        = r_top.id;
        o_ram_req.wr_data.remaining = rem_dec;
        o_ram_req.wr_data.codes     = r_top.codes;
        o_ram_req.rd_addr           = ADDR_W'(n_fill - FILL_W'(2));
    end

    always_comb begin
        o_result.has_parent      = has_parent;
        o_result.parent_id       = has_parent ? r_top.id : '0;
        o_result.parent_codes    = has_parent ? (r_top.codes & mask) : '0;
        o_result.child_codes     = i_item.current_codes & mask;
        o_result.component_count = roots_step;
        o_result.stack_overflow  = push_req && !push_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_roots <= '0;
        end else begin
            r_fill  <= n_fill;
            r_roots <= n_roots;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_top <= n_top;
        end
    end

endmodule

/* design/pctx_checker.sv */
// Port-level checker for the preorder parent context tracker and its bind statement.
// Uses pctx_pkg and the macros in assert_macros.svh.
`include "assert_macros.svh"

module pctx_checker
    import pctx_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_out_valid,
    input logic      i_out_stall,
    input t_out_item i_out_data
);

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall, i_out_valid && $stable(i_out_data))
    `ASSERT_SAME(a_root_zero_parent, i_clk, i_rst_n, i_out_valid && !i_out_data.has_parent, (i_out_data.parent_id == '0) && (i_out_data.parent_codes == '0))
    `ASSERT_SAME(a_root_counted, i_clk, i_rst_n, i_out_valid && !i_out_data.has_parent, i_out_data.component_count != '0)
    `ASSERT_SAME(a_overflow_full, i_clk, i_rst_n, i_out_valid && i_out_data.stack_overflow, i_out_data.has_parent)

endmodule

bind preorder_parent_context_tracker pctx_checker u_pctx_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);
